>>> hdl/hpm_pkg.sv
// shared types, constants and hash function of the linear probe hash map
package hpm_pkg;

  localparam int DEF_SLOTS = 1024;
  localparam int KEY_W     = 64;
  localparam int VAL_W     = 32;
  localparam int SLOT_W    = 10;
  localparam int CNT_W     = 10;
  localparam int ENTRY_W   = KEY_W + VAL_W;

  localparam logic [1:0] FN_LOOKUP = 2'd0;
  localparam logic [1:0] FN_INSERT = 2'd1;
  localparam logic [1:0] FN_ERASE  = 2'd2;
  localparam logic [1:0] FN_READ   = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_GAP,
    ST_REINS,
    ST_RDSLOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              found;
    logic              created;
    logic              full_res;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
  } res_t;

  // unmasked home hash, caller keeps the low index bits
  function automatic logic [KEY_W-1:0] home_hash(logic [KEY_W-1:0] k);
    return (k >> 4) ^ (k >> 16);
  endfunction

endpackage

>>> hdl/hpm_ram.sv
// generic single write, single read RAM with registered read data
module hpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/hpm_engine.sv
// probe sequencer: walks the entry memory for lookup, insert, erase and slot reads
module hpm_engine #(
  parameter int TABLE_SLOTS = hpm_pkg::DEF_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             req_valid,
  input  logic [1:0]                       req_func,
  input  logic [hpm_pkg::KEY_W-1:0]        req_key,
  input  logic [hpm_pkg::VAL_W-1:0]        req_new_value,
  input  logic [hpm_pkg::SLOT_W-1:0]       req_slot_index,
  output logic                             busy,
  output logic                             res_valid,
  input  logic                             res_take,
  output hpm_pkg::res_t                    res,
  output logic                             ram_we,
  output logic [$clog2(TABLE_SLOTS)-1:0]   ram_waddr,
  output logic [hpm_pkg::ENTRY_W-1:0]      ram_wdata,
  output logic [$clog2(TABLE_SLOTS)-1:0]   ram_raddr,
  input  logic [hpm_pkg::ENTRY_W-1:0]      ram_rdata
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int IW = AW + hpm_pkg::SLOT_W;
  localparam logic [AW-1:0] HALF = AW'(TABLE_SLOTS / 2);
  localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);
  localparam logic [AW-1:0] ONE  = AW'(1);

  hpm_pkg::state_t state_r, state_nxt;

  logic [1:0]                   func_r, func_nxt;
  logic [hpm_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [hpm_pkg::VAL_W-1:0]    nv_r, nv_nxt;
  logic [AW-1:0]                ptr_r, ptr_nxt;
  logic [AW-1:0]                gap_r, gap_nxt;
  logic [hpm_pkg::KEY_W-1:0]    mk_r, mk_nxt;
  logic [hpm_pkg::VAL_W-1:0]    mv_r, mv_nxt;
  logic [AW-1:0]                occ_r, occ_nxt;
  logic [AW-1:0]                clr_r, clr_nxt;
  hpm_pkg::res_t                res_r, res_nxt;
  logic                         fwd_hit_r;
  logic [hpm_pkg::ENTRY_W-1:0]  fwd_data_r;

  logic [hpm_pkg::ENTRY_W-1:0]  q;
  logic [hpm_pkg::KEY_W-1:0]    qk;
  logic [hpm_pkg::VAL_W-1:0]    qv;
  logic [hpm_pkg::KEY_W-1:0]    hq;
  logic [hpm_pkg::KEY_W-1:0]    hk;
  logic [IW-1:0]                idx_w;
  logic [IW-1:0]                ptr_w;
  logic [IW-1:0]                occ_w;
  logic                         idx_ok;

  // a read issued in the same cycle as a write to that slot sees the new entry
  assign q  = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign qk = q[hpm_pkg::ENTRY_W-1 -: hpm_pkg::KEY_W];
  assign qv = q[hpm_pkg::VAL_W-1:0];
  assign hq = hpm_pkg::home_hash(qk);
  assign hk = hpm_pkg::home_hash(req_key);

  assign idx_w  = IW'(req_slot_index);
  assign ptr_w  = IW'(ptr_r);
  assign occ_w  = IW'(occ_r);
  assign idx_ok = int'(req_slot_index) < TABLE_SLOTS;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpm_pkg::ST_CLEAR: begin
        if (clr_r == LAST) state_nxt = hpm_pkg::ST_IDLE;
      end
      hpm_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_func == hpm_pkg::FN_READ) begin
            state_nxt = idx_ok ? hpm_pkg::ST_RDSLOT : hpm_pkg::ST_DONE;
          end else if (req_key == '0) begin
            state_nxt = hpm_pkg::ST_DONE;
          end else begin
            state_nxt = hpm_pkg::ST_PROBE;
          end
        end
      end
      hpm_pkg::ST_PROBE: begin
        if (qk == key_r) begin
          state_nxt = (func_r == hpm_pkg::FN_ERASE) ? hpm_pkg::ST_GAP : hpm_pkg::ST_DONE;
        end else if (qk == '0) begin
          state_nxt = hpm_pkg::ST_DONE;
        end
      end
      hpm_pkg::ST_GAP: begin
        state_nxt = (qk == '0) ? hpm_pkg::ST_DONE : hpm_pkg::ST_REINS;
      end
      hpm_pkg::ST_REINS: begin
        if (qk == '0) state_nxt = hpm_pkg::ST_GAP;
      end
      hpm_pkg::ST_RDSLOT: state_nxt = hpm_pkg::ST_DONE;
      hpm_pkg::ST_DONE: begin
        if (res_take) state_nxt = hpm_pkg::ST_IDLE;
      end
      default: state_nxt = hpm_pkg::ST_CLEAR;
    endcase
  end

  // memory controls and datapath
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = '0;
    ram_raddr = ptr_r;
    func_nxt  = func_r;
    key_nxt   = key_r;
    nv_nxt    = nv_r;
    ptr_nxt   = ptr_r;
    gap_nxt   = gap_r;
    mk_nxt    = mk_r;
    mv_nxt    = mv_r;
    occ_nxt   = occ_r;
    clr_nxt   = clr_r;
    res_nxt   = res_r;
    case (state_r)
      hpm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + ONE;
      end
      hpm_pkg::ST_IDLE: begin
        if (req_valid) begin
          func_nxt = req_func;
          key_nxt  = req_key;
          nv_nxt   = req_new_value;
          res_nxt  = '0;
          if (req_func == hpm_pkg::FN_READ) begin
            ram_raddr    = idx_w[AW-1:0];
            res_nxt.slot = req_slot_index;
          end else begin
            ram_raddr = hk[AW-1:0];
            ptr_nxt   = hk[AW-1:0];
          end
        end
      end
      hpm_pkg::ST_PROBE: begin
        if (qk == key_r) begin
          res_nxt.found = 1'b1;
          res_nxt.slot  = ptr_w[hpm_pkg::SLOT_W-1:0];
          res_nxt.value = qv;
          if (func_r == hpm_pkg::FN_ERASE) begin
            ram_we    = 1'b1;
            ram_waddr = ptr_r;
            occ_nxt   = occ_r - ONE;
            gap_nxt   = ptr_r + ONE;
            ram_raddr = ptr_r + ONE;
          end
        end else if (qk == '0) begin
          if (func_r == hpm_pkg::FN_INSERT) begin
            if (occ_r >= HALF) begin
              res_nxt.full_res = 1'b1;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = ptr_r;
              ram_wdata       = {key_r, nv_r};
              occ_nxt         = occ_r + ONE;
              res_nxt.created = 1'b1;
              res_nxt.slot    = ptr_w[hpm_pkg::SLOT_W-1:0];
              res_nxt.value   = nv_r;
            end
          end
        end else begin
          ptr_nxt   = ptr_r + ONE;
          ram_raddr = ptr_r + ONE;
        end
      end
      hpm_pkg::ST_GAP: begin
        // pull the next cluster entry out and walk from its home slot
        if (qk != '0) begin
          mk_nxt    = qk;
          mv_nxt    = qv;
          ram_we    = 1'b1;
          ram_waddr = gap_r;
          ptr_nxt   = hq[AW-1:0];
          ram_raddr = hq[AW-1:0];
        end
      end
      hpm_pkg::ST_REINS: begin
        if (qk == '0) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_r;
          ram_wdata = {mk_r, mv_r};
          gap_nxt   = gap_r + ONE;
          ram_raddr = gap_r + ONE;
        end else begin
          ptr_nxt   = ptr_r + ONE;
          ram_raddr = ptr_r + ONE;
        end
      end
      hpm_pkg::ST_RDSLOT: begin
        res_nxt.found = (qk != '0);
        res_nxt.key   = qk;
        res_nxt.value = (qk != '0) ? qv : '0;
      end
      hpm_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res       = res_r;
    res.count = occ_w[hpm_pkg::CNT_W-1:0];
  end

  assign busy      = (state_r != hpm_pkg::ST_IDLE);
  assign res_valid = (state_r == hpm_pkg::ST_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hpm_pkg::ST_CLEAR;
      clr_r     <= '0;
      occ_r     <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      occ_r     <= occ_nxt;
      fwd_hit_r <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    nv_r       <= nv_nxt;
    ptr_r      <= ptr_nxt;
    gap_r      <= gap_nxt;
    mk_r       <= mk_nxt;
    mv_r       <= mv_nxt;
    res_r      <= res_nxt;
    fwd_data_r <= ram_wdata;
  end

endmodule

>>> hdl/linear_probe_hash_map.sv
// linear probe hash map: 64-bit keys with 32-bit payloads in open addressing
//
// Input channel in_* carries one request: in_func selects lookup, find-or-insert,
// erase or read of slot in_slot_index. Each request gives exactly one result on
// out_*. Both channels move an item on a clock edge with valid high, stall low.
// Keys and payloads sit in one entry RAM with a registered read; the probe
// sequencer reads one slot per cycle. Erase also walks the rest of the cluster,
// moving each following entry back toward its home slot.
// One request is in flight at a time; in_stall is high until its result has
// been handed to the output register, which holds it while out_stall is high.
// A new request is taken while that result still waits.
// Reset (synchronous, rst_n low) zeroes the count, then a clearing pass
// empties the table by writing every slot, with in_stall high.
// New keys are refused with out_full_res once the table is half full.
module linear_probe_hash_map #(
  parameter int TABLE_SLOTS = hpm_pkg::DEF_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [hpm_pkg::KEY_W-1:0]     in_key,
  input  logic [hpm_pkg::VAL_W-1:0]     in_new_value,
  input  logic [hpm_pkg::SLOT_W-1:0]    in_slot_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic                          out_created,
  output logic                          out_full_res,
  output logic [hpm_pkg::VAL_W-1:0]     out_value_out,
  output logic [hpm_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [hpm_pkg::KEY_W-1:0]     out_key_out,
  output logic [hpm_pkg::CNT_W-1:0]     out_entry_count
);

  localparam int AW = $clog2(TABLE_SLOTS);

  logic                         busy;
  logic                         res_valid;
  logic                         res_take;
  hpm_pkg::res_t                res;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [hpm_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [hpm_pkg::ENTRY_W-1:0]  ram_rdata;

  logic                         out_valid_r, out_valid_nxt;
  hpm_pkg::res_t                out_res_r;

  hpm_ram #(
    .WIDTH (hpm_pkg::ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hpm_engine #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_valid),
    .req_func       (in_func),
    .req_key        (in_key),
    .req_new_value  (in_new_value),
    .req_slot_index (in_slot_index),
    .busy           (busy),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  assign in_stall = busy;

  // output register loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_res_r.found;
  assign out_created     = out_res_r.created;
  assign out_full_res    = out_res_r.full_res;
  assign out_value_out   = out_res_r.value;
  assign out_slot_out    = out_res_r.slot;
  assign out_key_out     = out_res_r.key;
  assign out_entry_count = out_res_r.count;

  // one request at a time: the sequencer holds off input right after taking one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

  a_created_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_created) |-> (!out_found && !out_full_res))
    else $error("created result also flagged found or full");

  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_res) |-> (!out_found && out_value_out == '0))
    else $error("refused insert carries an entry");

  a_key_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_key_out == '0))
    else $error("key returned without an occupied slot");

endmodule
